[src/msp_frame_receiver_macros.svh]
// Assertion macros for the MSP frame receiver.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MSP_FRAME_RECEIVER_MACROS_SVH
`define MSP_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define MFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MFR_ASSERT_NOW(lbl, ante, cons, msg)
`define MFR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/mfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MSP frame receiver package
// Shared result type and buffer status used by the receiver modules.
// ----------------------------------------------------------------------------
package mfr_pkg;

    localparam int unsigned LEVEL_W = 2;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] command;
        logic        version;
        logic        frame_good;
        logic [15:0] payload_length;
    } mfr_result_t;

    typedef struct packed {
        logic               space;
        logic [LEVEL_W-1:0] level;
    } mfr_buf_status_t;

endpackage
`default_nettype wire

[src/mfr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MSP frame receiver channels
// Valid/ready interfaces for the received bytes and the parsed results.
// ----------------------------------------------------------------------------
interface mfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfr_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] command;
    logic        version;
    logic        frame_good;
    logic [15:0] payload_length;

    modport source (output valid, output kind, output data_byte, output command,
                    output version, output frame_good, output payload_length,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input command,
                    input version, input frame_good, input payload_length,
                    output ready);
endinterface
`default_nettype wire

[src/msp_frame_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MSP frame receiver
// Parses '$M' (v1, XOR checksum) and '$X' (v2, CRC-16) frames from a byte
// stream and streams out payload bytes followed by a frame-end result.
//
// Channels: rx carries one received byte per transfer; msg carries one
// result per transfer, either a payload byte (kind 0) or a frame end
// (kind 1) with the check result, command, version and payload length.
// Bytes that produce no result (hunting, header, size, command, first
// CRC byte) are consumed silently.
// Latency path: a byte taken from rx sits in the input register; when the
// frame state advances, its result is written into the result queue, from
// which it is offered on msg.
// Throughput: one byte per cycle while the result queue has room; the frame
// state and the byte-wide CRC update are combinational between the input
// register and the two-entry result queue.
// Reset: all control state clears; the parser starts hunting for '$' and
// the result queue is empty.
// Stalls: when msg is held off, up to two results queue up; once the queue
// is full the input register holds its byte and rx.ready drops.
// ----------------------------------------------------------------------------
`include "msp_frame_receiver_macros.svh"

module msp_frame_receiver (
    input  wire logic clk,
    input  wire logic rst_n,
    mfr_rx_if.sink    rx,
    mfr_res_if.source msg
);
    import mfr_pkg::*;

    logic            res_valid;
    mfr_result_t     res_data;
    mfr_buf_status_t stat;

    mfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .stat      (stat),
        .res_valid (res_valid),
        .res       (res_data)
    );

    mfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .res       (msg),
        .stat      (stat)
    );

    // A payload transfer never claims a good frame, and a frame end has no data.
    `MFR_ASSERT_NOW(a_payload_not_good, msg.valid && msg.kind == KIND_PAYLOAD, !msg.frame_good, "payload result flagged good")
    `MFR_ASSERT_NOW(a_end_no_data, msg.valid && msg.kind == KIND_FRAME_END, msg.data_byte == 8'h00, "frame end carries data")
    // v1 frames carry only 8-bit size and command fields.
    `MFR_ASSERT_NOW(a_v1_narrow, msg.valid && !msg.version, msg.command[15:8] == 8'h00 && msg.payload_length[15:8] == 8'h00, "v1 result has wide fields")
    // A full queue with no output transfer must not accept another result.
    `MFR_ASSERT_NEXT(a_no_overflow, !stat.space && !(msg.valid && msg.ready), !stat.space && $stable(stat.level), "result queue overflow")

endmodule
`default_nettype wire

[src/mfr_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MSP frame parser
// Input byte register followed by the single-step frame state machine.
// ----------------------------------------------------------------------------
module mfr_parser (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    mfr_rx_if.sink                        rx,
    input  wire mfr_pkg::mfr_buf_status_t stat,
    output logic                          res_valid,
    output mfr_pkg::mfr_result_t          res
);
    import mfr_pkg::*;

    localparam logic [3:0] PH_HUNT     = 4'd0;
    localparam logic [3:0] PH_HDR1     = 4'd1;
    localparam logic [3:0] PH_HDR2     = 4'd2;
    localparam logic [3:0] PH_V1_SIZE  = 4'd3;
    localparam logic [3:0] PH_V1_CMD   = 4'd4;
    localparam logic [3:0] PH_V2_FLAGS = 4'd5;
    localparam logic [3:0] PH_V2_HDR   = 4'd6;
    localparam logic [3:0] PH_PAYLOAD  = 4'd7;
    localparam logic [3:0] PH_V1_CHECK = 4'd8;
    localparam logic [3:0] PH_V2_CRCLO = 4'd9;
    localparam logic [3:0] PH_V2_CRCHI = 4'd10;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] HIDX_LEN_LO = 2'd0;
    localparam logic [1:0] HIDX_LEN_HI = 2'd1;
    localparam logic [1:0] HIDX_CMD_LO = 2'd2;
    localparam logic [1:0] HIDX_CMD_HI = 2'd3;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    logic [3:0]  phase_reg,   phase_next;
    logic        is_v2_reg,   is_v2_next;
    logic [1:0]  hidx_reg,    hidx_next;
    logic [7:0]  second_reg,  second_next;
    logic [15:0] length_reg,  length_next;
    logic [15:0] command_reg, command_next;
    logic [15:0] left_reg,    left_next;
    logic [7:0]  xor_reg,     xor_next;
    logic [15:0] crc_reg,     crc_next;
    logic [7:0]  crc_lo_reg,  crc_lo_next;

    logic        emit;
    logic        emit_kind;
    logic [7:0]  emit_data;
    logic        emit_good;
    logic [3:0]  check_phase;

    // The byte register drains whenever the result buffer has room.
    assign advance  = in_valid_reg && stat.space;
    assign rx.ready = !in_valid_reg || stat.space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    assign check_phase = is_v2_reg ? PH_V2_CRCLO : PH_V1_CHECK;

    always_comb
    begin
        phase_next   = phase_reg;
        is_v2_next   = is_v2_reg;
        hidx_next    = hidx_reg;
        second_next  = second_reg;
        length_next  = length_reg;
        command_next = command_reg;
        left_next    = left_reg;
        xor_next     = xor_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        emit         = 1'b0;
        emit_kind    = KIND_PAYLOAD;
        emit_data    = 8'h00;
        emit_good    = 1'b0;

        unique case (phase_reg)
            PH_HDR1:
            begin
                second_next = in_byte_reg;
                phase_next  = PH_HDR2;
            end
            PH_HDR2:
            begin
                if ((second_reg == CH_M || second_reg == CH_X) &&
                    (in_byte_reg == CH_GT || in_byte_reg == CH_BANG))
                begin
                    is_v2_next   = (second_reg == CH_X);
                    length_next  = 16'h0000;
                    command_next = 16'h0000;
                    xor_next     = 8'h00;
                    crc_next     = 16'h0000;
                    hidx_next    = HIDX_LEN_LO;
                    phase_next   = (second_reg == CH_X) ? PH_V2_FLAGS : PH_V1_SIZE;
                end
                else
                begin
                    // Both header bytes are dropped; they are not rescanned.
                    phase_next = PH_HUNT;
                end
            end
            PH_V1_SIZE:
            begin
                length_next = {8'h00, in_byte_reg};
                xor_next    = in_byte_reg;
                phase_next  = PH_V1_CMD;
            end
            PH_V1_CMD:
            begin
                command_next = {8'h00, in_byte_reg};
                xor_next     = xor_reg ^ in_byte_reg;
                left_next    = length_reg;
                phase_next   = (length_reg != 16'h0000) ? PH_PAYLOAD : check_phase;
            end
            PH_V2_FLAGS:
            begin
                crc_next   = crc_byte(16'h0000, in_byte_reg);
                hidx_next  = HIDX_LEN_LO;
                phase_next = PH_V2_HDR;
            end
            PH_V2_HDR:
            begin
                crc_next = crc_byte(crc_reg, in_byte_reg);
                case (hidx_reg)
                    HIDX_LEN_LO: length_next  = {length_reg[15:8], in_byte_reg};
                    HIDX_LEN_HI: length_next  = {in_byte_reg, length_reg[7:0]};
                    HIDX_CMD_LO: command_next = {command_reg[15:8], in_byte_reg};
                    default:     command_next = {in_byte_reg, command_reg[7:0]};
                endcase
                if (hidx_reg == HIDX_CMD_HI)
                begin
                    hidx_next  = HIDX_LEN_LO;
                    left_next  = length_reg;
                    phase_next = (length_reg != 16'h0000) ? PH_PAYLOAD : check_phase;
                end
                else
                begin
                    hidx_next = hidx_reg + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                if (is_v2_reg)
                    crc_next = crc_byte(crc_reg, in_byte_reg);
                else
                    xor_next = xor_reg ^ in_byte_reg;
                emit      = 1'b1;
                emit_data = in_byte_reg;
                left_next = left_reg - 16'd1;
                if (left_reg == 16'd1)
                    phase_next = check_phase;
            end
            PH_V1_CHECK:
            begin
                emit       = 1'b1;
                emit_kind  = KIND_FRAME_END;
                emit_good  = (xor_reg == in_byte_reg);
                phase_next = PH_HUNT;
            end
            PH_V2_CRCLO:
            begin
                crc_lo_next = in_byte_reg;
                phase_next  = PH_V2_CRCHI;
            end
            PH_V2_CRCHI:
            begin
                emit       = 1'b1;
                emit_kind  = KIND_FRAME_END;
                emit_good  = (crc_reg == {in_byte_reg, crc_lo_reg});
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = (in_byte_reg == CH_DOLLAR) ? PH_HDR1 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            is_v2_reg   <= 1'b0;
            hidx_reg    <= HIDX_LEN_LO;
            second_reg  <= 8'h00;
            length_reg  <= 16'h0000;
            command_reg <= 16'h0000;
            left_reg    <= 16'h0000;
            xor_reg     <= 8'h00;
            crc_reg     <= 16'h0000;
            crc_lo_reg  <= 8'h00;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            is_v2_reg   <= is_v2_next;
            hidx_reg    <= hidx_next;
            second_reg  <= second_next;
            length_reg  <= length_next;
            command_reg <= command_next;
            left_reg    <= left_next;
            xor_reg     <= xor_next;
            crc_reg     <= crc_next;
            crc_lo_reg  <= crc_lo_next;
        end
    end

    assign res_valid          = advance && emit;
    assign res.kind           = emit_kind;
    assign res.data_byte      = emit_data;
    assign res.command        = command_reg;
    assign res.version        = is_v2_reg;
    assign res.frame_good     = emit_good;
    assign res.payload_length = length_reg;

endmodule
`default_nettype wire

[src/mfr_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MSP frame result buffer
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module mfr_out_buf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire mfr_pkg::mfr_result_t  push_data,
    mfr_res_if.source                  res,
    output mfr_pkg::mfr_buf_status_t   stat
);
    import mfr_pkg::*;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(2);

    mfr_result_t        entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               pop;
    mfr_result_t        head;

    assign pop  = res.valid && res.ready;
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   level_next = level_reg + LEVEL_W'(1);
            2'b01:   level_next = level_reg - LEVEL_W'(1);
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign stat.space  = (level_reg != LEVEL_FULL);
    assign stat.level  = level_reg;

    assign res.valid          = (level_reg != '0);
    assign res.kind           = head.kind;
    assign res.data_byte      = head.data_byte;
    assign res.command        = head.command;
    assign res.version        = head.version;
    assign res.frame_good     = head.frame_good;
    assign res.payload_length = head.payload_length;

endmodule
`default_nettype wire

[bench/mfr_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP frame receiver bench package
// Framing characters and the CRC-16 byte update, shared by the stimulus
// that builds frames and the checker that predicts the parser.
// ----------------------------------------------------------------------------
package mfr_tb_pkg;

    localparam logic [7:0] SYNC_CHAR = 8'h24;  // '$'
    localparam logic [7:0] V1_MARK   = 8'h4D;  // 'M'
    localparam logic [7:0] V2_MARK   = 8'h58;  // 'X'
    localparam logic [7:0] DIR_REPLY = 8'h3E;  // '>'
    localparam logic [7:0] DIR_ERROR = 8'h21;  // '!'

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[bench/msp_frame_receiver_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP frame receiver checker
// Watches the byte and result channels, runs its own frame parser on every
// accepted byte and compares each result transfer with the oldest predicted
// result. Reports the mismatch count and the number of results still owed.
// ----------------------------------------------------------------------------
module msp_frame_receiver_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mfr_rx_if           rx,
    mfr_res_if          msg,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    import mfr_pkg::*;
    import mfr_tb_pkg::*;

    typedef enum logic [3:0] {
        P_HUNT,
        P_HDR1,
        P_HDR2,
        P_V1_LEN,
        P_V1_CMD,
        P_V2_FLAGS,
        P_V2_HDR,
        P_PAYLOAD,
        P_V1_SUM,
        P_V2_CRC_LO,
        P_V2_CRC_HI
    } parse_phase_e;

    parse_phase_e phase;
    logic         v2_frame;
    logic [2:0]   hdr_pos;
    logic [7:0]   mark_byte;
    logic [15:0]  frame_len;
    logic [15:0]  frame_cmd;
    logic [15:0]  remaining;
    logic [7:0]   xor_sum;
    logic [15:0]  crc;
    logic [7:0]   crc_lo;
    int unsigned  result_idx;

    mfr_result_t parsed_results_q[$];

    task automatic push_result(input logic kind, input logic [7:0] data,
                               input logic good);
        mfr_result_t r;
        r.kind           = kind;
        r.data_byte      = data;
        r.command        = frame_cmd;
        r.version        = v2_frame;
        r.frame_good     = good;
        r.payload_length = frame_len;
        parsed_results_q = {parsed_results_q, r};
    endtask

    // Header done: an empty frame skips straight to its check bytes.
    task automatic enter_body();
        remaining = frame_len;
        if (remaining != 16'd0)
            phase = P_PAYLOAD;
        else
            phase = v2_frame ? P_V2_CRC_LO : P_V1_SUM;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        case (phase)
            P_HDR1:
            begin
                mark_byte = b;
                phase     = P_HDR2;
            end
            P_HDR2:
            begin
                // A bad header drops both bytes; neither is rescanned for sync.
                if ((mark_byte == V1_MARK || mark_byte == V2_MARK) &&
                    (b == DIR_REPLY || b == DIR_ERROR))
                begin
                    v2_frame  = (mark_byte == V2_MARK);
                    frame_len = 16'd0;
                    frame_cmd = 16'd0;
                    xor_sum   = 8'd0;
                    crc       = CRC_INIT;
                    hdr_pos   = 3'd0;
                    phase     = v2_frame ? P_V2_FLAGS : P_V1_LEN;
                end
                else
                begin
                    phase = P_HUNT;
                end
            end
            P_V1_LEN:
            begin
                frame_len = {8'h00, b};
                xor_sum   = b;
                phase     = P_V1_CMD;
            end
            P_V1_CMD:
            begin
                frame_cmd = {8'h00, b};
                xor_sum   = xor_sum ^ b;
                enter_body();
            end
            P_V2_FLAGS:
            begin
                crc     = crc16_update(CRC_INIT, b);
                hdr_pos = 3'd0;
                phase   = P_V2_HDR;
            end
            P_V2_HDR:
            begin
                crc = crc16_update(crc, b);
                case (hdr_pos[1:0])
                    2'd0: frame_len[7:0]  = b;
                    2'd1: frame_len[15:8] = b;
                    2'd2: frame_cmd[7:0]  = b;
                    default: frame_cmd[15:8] = b;
                endcase
                if (hdr_pos[1:0] == 2'd3)
                begin
                    hdr_pos = 3'd0;
                    enter_body();
                end
                else
                begin
                    hdr_pos = hdr_pos + 3'd1;
                end
            end
            P_PAYLOAD:
            begin
                if (v2_frame)
                    crc = crc16_update(crc, b);
                else
                    xor_sum = xor_sum ^ b;
                push_result(KIND_PAYLOAD, b, 1'b0);
                remaining = remaining - 16'd1;
                if (remaining == 16'd0)
                    phase = v2_frame ? P_V2_CRC_LO : P_V1_SUM;
            end
            P_V1_SUM:
            begin
                push_result(KIND_FRAME_END, 8'h00, xor_sum == b);
                phase = P_HUNT;
            end
            P_V2_CRC_LO:
            begin
                crc_lo = b;
                phase  = P_V2_CRC_HI;
            end
            P_V2_CRC_HI:
            begin
                push_result(KIND_FRAME_END, 8'h00, crc == {b, crc_lo});
                phase = P_HUNT;
            end
            default:
            begin
                phase = (b == SYNC_CHAR) ? P_HDR1 : P_HUNT;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        mfr_result_t want;
        mfr_result_t got;
        if (!rst_n)
        begin
            phase       = P_HUNT;
            v2_frame    = 1'b0;
            hdr_pos     = 3'd0;
            mark_byte   = 8'h00;
            frame_len   = 16'd0;
            frame_cmd   = 16'd0;
            remaining   = 16'd0;
            xor_sum     = 8'h00;
            crc         = CRC_INIT;
            crc_lo      = 8'h00;
            result_idx  = 0;
            mismatches  = 0;
            outstanding = 0;
            parsed_results_q.delete();
        end
        else
        begin
            if (msg.valid && msg.ready)
            begin
                got.kind           = msg.kind;
                got.data_byte      = msg.data_byte;
                got.command        = msg.command;
                got.version        = msg.version;
                got.frame_good     = msg.frame_good;
                got.payload_length = msg.payload_length;
                if (parsed_results_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("result %0d: unexpected kind=%0d data=%02h cmd=%04h",
                                 result_idx, got.kind, got.data_byte, got.command);
                    mismatches++;
                end
                else
                begin
                    want = parsed_results_q.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.command !== want.command || got.version !== want.version ||
                        got.frame_good !== want.frame_good ||
                        got.payload_length !== want.payload_length)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("res %0d exp: k=%0d d=%02h cmd=%04h v=%0d g=%0d len=%0d",
                                     result_idx, want.kind, want.data_byte, want.command,
                                     want.version, want.frame_good, want.payload_length);
                            $display("res %0d act: k=%0d d=%02h cmd=%04h v=%0d g=%0d len=%0d",
                                     result_idx, got.kind, got.data_byte, got.command,
                                     got.version, got.frame_good, got.payload_length);
                        end
                        mismatches++;
                    end
                end
                result_idx++;
            end
            if (rx.valid && rx.ready)
                parse_rx_byte(rx.rx_byte);
            outstanding = parsed_results_q.size();
        end
    end

endmodule

[bench/msp_frame_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP frame receiver testbench
// Drives the byte stream with hand-picked frames and then random v1/v2
// frames, broken headers, truncated frames and line noise, with random
// gaps on both channels. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module msp_frame_receiver_tb;
    import mfr_pkg::*;
    import mfr_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned BYTE_TARGET = 800;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycles     = 0;
    int unsigned bytes_sent = 0;
    bit          steady     = 1'b0;
    logic [7:0]  payload_q[$];

    mfr_rx_if  rx ();
    mfr_res_if msg ();

    msp_frame_receiver u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .msg   (msg)
    );

    msp_frame_receiver_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .msg         (msg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
    begin
        msg.ready <= steady || ($urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("msp_frame_receiver: mismatch");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    // A one-cycle gap before about one byte in five idles the input, unless steady.
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < 20)
        begin
            rx.valid <= 1'b0;
            @(negedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do @(posedge clk); while (!rx.ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Payload bytes come from payload_q first, then at random.
    task automatic send_frame(input bit v2, input logic [7:0] dir,
                              input logic [15:0] len, input logic [15:0] cmd,
                              input logic [7:0] flags, input bit corrupt);
        logic [39:0] head;
        logic [15:0] body_len;
        logic [15:0] crc;
        logic [7:0]  sum;
        logic [7:0]  b;
        body_len = v2 ? len : {8'h00, len[7:0]};
        crc      = CRC_INIT;
        sum      = len[7:0] ^ cmd[7:0];
        head     = {cmd[15:8], cmd[7:0], len[15:8], len[7:0], flags};
        send_byte(SYNC_CHAR);
        send_byte(v2 ? V2_MARK : V1_MARK);
        send_byte(dir);
        if (v2)
        begin
            for (int i = 0; i < 5; i++)
            begin
                b   = head[8*i +: 8];
                crc = crc16_update(crc, b);
                send_byte(b);
            end
        end
        else
        begin
            send_byte(len[7:0]);
            send_byte(cmd[7:0]);
        end
        for (int i = 0; i < int'(body_len); i++)
        begin
            b   = (i < payload_q.size()) ? payload_q[i] : 8'($urandom);
            crc = crc16_update(crc, b);
            sum = sum ^ b;
            send_byte(b);
        end
        payload_q.delete();
        if (corrupt)
        begin
            crc = crc ^ (16'd1 << $urandom_range(15));
            sum = sum ^ (8'd1 << $urandom_range(7));
        end
        if (v2)
        begin
            send_byte(crc[7:0]);
            send_byte(crc[15:8]);
        end
        else
        begin
            send_byte(sum);
        end
    endtask

    task automatic send_random_frame();
        bit          v2;
        int unsigned pick;
        logic [15:0] len;
        v2   = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 10)
            len = 16'd0;
        else if (pick < 85)
            len = 16'($urandom_range(1, 12));
        else if (pick < 97)
            len = 16'($urandom_range(13, 64));
        else
            len = v2 ? 16'($urandom_range(65, 300)) : 16'($urandom_range(200, 255));
        send_frame(v2, $urandom_range(1) ? DIR_ERROR : DIR_REPLY, len,
                   v2 ? 16'($urandom) : {8'h00, 8'($urandom)}, 8'($urandom),
                   $urandom_range(99) < 20);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned cut;
        logic [7:0]  mark;
        logic [7:0]  dir;
        logic [7:0]  len;
        bit          drained;
        bit          longest_done;

        rx.valid     = 1'b0;
        rx.rx_byte   = 8'h00;
        drained      = 1'b0;
        longest_done = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: good v2 with extreme header fields, empty v1, a sync byte
        // inside a bad header, and a v1 frame with a wrong checksum.
        payload_q = {payload_q, 8'h00};
        send_frame(1'b1, DIR_REPLY, 16'd1, 16'hFFFF, 8'hFF, 1'b0);
        send_frame(1'b0, DIR_ERROR, 16'd0, 16'h00FF, 8'h00, 1'b0);
        send_byte(SYNC_CHAR);
        send_byte(SYNC_CHAR);
        send_byte(V1_MARK);
        payload_q = {payload_q, 8'hFF};
        send_frame(1'b0, DIR_REPLY, 16'd1, 16'h0000, 8'h00, 1'b1);

        while (bytes_sent < BYTE_TARGET)
        begin
            steady = (bytes_sent >= 100 && bytes_sent < 250);

            if (!drained && bytes_sent >= 500)
            begin
                rx.valid <= 1'b0;
                do @(negedge clk); while (outstanding != 0);
                drained = 1'b1;
            end

            // The longest v1 frame and a v2 frame whose size needs both bytes.
            if (!longest_done && bytes_sent >= 260)
            begin
                send_frame(1'b0, DIR_REPLY, 16'd255, 16'h00A5, 8'h00, 1'b0);
                send_frame(1'b1, DIR_ERROR, 16'h0100, 16'h8001, 8'h5A, 1'b0);
                longest_done = 1'b1;
            end

            pick = $urandom_range(99);
            if (pick < 72)
            begin
                send_random_frame();
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            else if (pick < 92)
            begin
                // Broken header; a valid mark is never followed by a valid direction.
                case ($urandom_range(3))
                    0: mark = V1_MARK;
                    1: mark = V2_MARK;
                    2: mark = SYNC_CHAR;
                    default: mark = 8'($urandom);
                endcase
                if (mark == V1_MARK || mark == V2_MARK)
                begin
                    dir = $urandom_range(1) ? SYNC_CHAR : 8'($urandom);
                    if (dir == DIR_REPLY || dir == DIR_ERROR)
                        dir = 8'h00;
                end
                else
                begin
                    case ($urandom_range(2))
                        0: dir = DIR_REPLY;
                        1: dir = DIR_ERROR;
                        default: dir = 8'($urandom);
                    endcase
                end
                send_byte(SYNC_CHAR);
                send_byte(mark);
                send_byte(dir);
            end
            else
            begin
                // Truncated v1 frame: the next bytes are taken as its payload.
                len = 8'($urandom_range(2, 20));
                cut = $urandom_range(0, len - 1);
                send_byte(SYNC_CHAR);
                send_byte(V1_MARK);
                send_byte($urandom_range(1) ? DIR_ERROR : DIR_REPLY);
                send_byte(len);
                send_byte(8'($urandom));
                repeat (cut) send_byte(8'($urandom));
            end
        end

        steady = 1'b0;
        rx.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("msp_frame_receiver: match");
        else
            $display("msp_frame_receiver: mismatch");
        $finish;
    end

endmodule
